[rtl/cvg_pkg.sv]
package cvg_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int IDX_W         = 11;
    localparam int SEG_W         = 11;
    localparam int CRD_W         = 16;
    localparam int PT_W          = 18;
    localparam int DIV_STAGES    = IDX_W + ANGLE_BITS;
    localparam int TURN_W        = 32;
    localparam int XY_W          = 34;
    localparam int PROD_W        = XY_W + CRD_W + 1;
    localparam int FRAC_SH       = 30;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);

    localparam logic signed [XY_W-1:0]   GAIN_Q30    = XY_W'(652032874);
    localparam logic signed [TURN_W-1:0] QUARTER_POS = TURN_W'(1073741824);
    localparam logic signed [TURN_W-1:0] QUARTER_NEG = -TURN_W'(1073741824);

    localparam logic [CRD_W-1:0] RST_CENTER_X = '0;
    localparam logic [CRD_W-1:0] RST_CENTER_Y = '0;
    localparam logic [CRD_W-1:0] RST_RADIUS   = CRD_W'(2560);
    localparam logic [SEG_W-1:0] RST_SEGMENTS = SEG_W'(100);

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_RADIUS   = 2'd2,
        REG_SEGMENTS = 2'd3
    } cvg_reg_t;

    typedef struct packed {
        logic signed [TURN_W-1:0] z;
        logic                     flip;
    } cvg_item_t;

    function automatic logic signed [XY_W-1:0] atan_turn(input int i);
        logic signed [XY_W-1:0] a;
        a = '0;
        case (i)
            0:  a = XY_W'(536870912);
            1:  a = XY_W'(316933406);
            2:  a = XY_W'(167458907);
            3:  a = XY_W'(85004756);
            4:  a = XY_W'(42667331);
            5:  a = XY_W'(21354465);
            6:  a = XY_W'(10679838);
            7:  a = XY_W'(5340245);
            8:  a = XY_W'(2670163);
            9:  a = XY_W'(1335087);
            10: a = XY_W'(667544);
            11: a = XY_W'(333772);
            12: a = XY_W'(166886);
            13: a = XY_W'(83443);
            14: a = XY_W'(41722);
            15: a = XY_W'(20861);
            16: a = XY_W'(10430);
            17: a = XY_W'(5215);
            18: a = XY_W'(2608);
            19: a = XY_W'(1304);
            20: a = XY_W'(652);
            21: a = XY_W'(326);
            22: a = XY_W'(163);
            23: a = XY_W'(81);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[rtl/cvg_front.sv]
module cvg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cvg_pkg::IDX_W-1:0]     vertex_index,
    input  logic [cvg_pkg::SEG_W-1:0]     segments,
    input  logic                          q_full,
    output logic                          q_push,
    output cvg_pkg::cvg_item_t            q_item
);

    localparam int N = cvg_pkg::DIV_STAGES;

    logic                            en;
    logic                            v_reg   [N];
    logic [cvg_pkg::IDX_W-1:0]       idx_reg [N];
    logic [cvg_pkg::SEG_W-1:0]       rem_reg [N];
    logic [cvg_pkg::ANGLE_BITS-1:0]  q_reg   [N];

    logic [cvg_pkg::IDX_W-1:0]       idx_in  [N];
    logic [cvg_pkg::SEG_W-1:0]       rem_in  [N];
    logic [cvg_pkg::ANGLE_BITS-1:0]  q_in    [N];
    logic [cvg_pkg::SEG_W-1:0]       rem_next [N];
    logic [cvg_pkg::ANGLE_BITS-1:0]  q_next  [N];

    assign en       = !(v_reg[N-1] && q_full);
    assign in_ready = en;

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_div
            localparam int P = N - 1 - k;
            logic            dbit;
            logic [cvg_pkg::SEG_W:0] t;
            logic            ge;

            if (k == 0) begin : g_first
                assign idx_in[k] = vertex_index;
                assign rem_in[k] = '0;
                assign q_in[k]   = '0;
            end
            else begin : g_rest
                assign idx_in[k] = idx_reg[k-1];
                assign rem_in[k] = rem_reg[k-1];
                assign q_in[k]   = q_reg[k-1];
            end

            if (P >= cvg_pkg::ANGLE_BITS) begin : g_bit
                assign dbit = idx_in[k][P - cvg_pkg::ANGLE_BITS];
            end
            else begin : g_zero
                assign dbit = 1'b0;
            end

            assign t           = {rem_in[k], dbit};
            assign ge          = t >= {1'b0, segments};
            assign rem_next[k] = ge ? cvg_pkg::SEG_W'(t - {1'b0, segments})
                                    : t[cvg_pkg::SEG_W-1:0];
            assign q_next[k]   = {q_in[k][cvg_pkg::ANGLE_BITS-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    idx_reg[k] <= idx_in[k];
                    rem_reg[k] <= rem_next[k];
                    q_reg[k]   <= q_next[k];
                end
            end
        end
    endgenerate

    logic [cvg_pkg::ANGLE_BITS-1:0] phase;
    logic signed [cvg_pkg::TURN_W-1:0] turn;
    logic flip;

    // fold angles past a quarter turn onto the right half-plane
    always_comb
    begin
        phase = (segments == '0) ? '0 : q_reg[N-1];
        turn  = {phase, {(cvg_pkg::TURN_W - cvg_pkg::ANGLE_BITS){1'b0}}};
        flip  = (turn > cvg_pkg::QUARTER_POS) || (turn < cvg_pkg::QUARTER_NEG);
        q_item.flip = flip;
        q_item.z    = flip ? {~turn[cvg_pkg::TURN_W-1], turn[cvg_pkg::TURN_W-2:0]} : turn;
    end

    assign q_push = en && v_reg[N-1];

endmodule

[rtl/cvg_queue.sv]
module cvg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cvg_pkg::cvg_item_t  push_item,
    input  logic                pop,
    output cvg_pkg::cvg_item_t  head,
    output logic                empty,
    output logic                full
);

    cvg_pkg::cvg_item_t              mem_reg [cvg_pkg::QDEPTH];
    logic [cvg_pkg::QPTR_W-1:0]      wp_reg, wp_next;
    logic [cvg_pkg::QPTR_W-1:0]      rp_reg, rp_next;
    logic [cvg_pkg::QPTR_W:0]        cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (cvg_pkg::QPTR_W+1)'(cvg_pkg::QDEPTH));
    assign head  = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop  ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (cvg_pkg::QPTR_W+1)'(push) - (cvg_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_item;
        end
    end

endmodule

[rtl/cvg_back.sv]
module cvg_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  cvg_pkg::cvg_item_t                q_head,
    output logic                              q_pop,
    input  logic [cvg_pkg::CRD_W-1:0]         center_x,
    input  logic [cvg_pkg::CRD_W-1:0]         center_y,
    input  logic [cvg_pkg::CRD_W-1:0]         radius,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cvg_pkg::PT_W-1:0]          point_x,
    output logic [cvg_pkg::PT_W-1:0]          point_y
);

    localparam int S  = cvg_pkg::CORDIC_STAGES;
    localparam int W  = cvg_pkg::XY_W;
    localparam int PW = cvg_pkg::PROD_W;
    localparam logic signed [PW-1:0] RND = PW'(1) <<< (cvg_pkg::FRAC_SH - 1);

    logic en;
    logic               cv_reg [S];
    logic               cf_reg [S];
    logic signed [W-1:0] cx_reg [S];
    logic signed [W-1:0] cy_reg [S];
    logic signed [W-1:0] cz_reg [S];

    logic signed [W-1:0] x_in [S];
    logic signed [W-1:0] y_in [S];
    logic signed [W-1:0] z_in [S];
    logic                f_in [S];

    logic                mv_reg;
    logic signed [PW-1:0] mx_reg, my_reg;
    logic                ov_reg;
    logic [cvg_pkg::PT_W-1:0] px_reg, py_reg;

    assign en    = !ov_reg || out_ready;
    assign q_pop = en && !q_empty;

    genvar i;
    generate
        for (i = 0; i < S; i++) begin : g_rot
            if (i == 0) begin : g_first
                assign x_in[i] = cvg_pkg::GAIN_Q30;
                assign y_in[i] = '0;
                assign z_in[i] = W'(q_head.z);
                assign f_in[i] = q_head.flip;
            end
            else begin : g_rest
                assign x_in[i] = cx_reg[i-1];
                assign y_in[i] = cy_reg[i-1];
                assign z_in[i] = cz_reg[i-1];
                assign f_in[i] = cf_reg[i-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cv_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    cv_reg[i] <= (i == 0) ? !q_empty : cv_reg[(i == 0) ? 0 : i-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cf_reg[i] <= f_in[i];
                    if (!z_in[i][W-1])
                    begin
                        cx_reg[i] <= x_in[i] - (y_in[i] >>> i);
                        cy_reg[i] <= y_in[i] + (x_in[i] >>> i);
                        cz_reg[i] <= z_in[i] - cvg_pkg::atan_turn(i);
                    end
                    else
                    begin
                        cx_reg[i] <= x_in[i] + (y_in[i] >>> i);
                        cy_reg[i] <= y_in[i] - (x_in[i] >>> i);
                        cz_reg[i] <= z_in[i] + cvg_pkg::atan_turn(i);
                    end
                end
            end
        end
    endgenerate

    logic signed [W-1:0]  cos_v, sin_v;
    logic signed [cvg_pkg::CRD_W:0] rad_s;
    logic signed [PW-1:0] sx, sy;
    logic [cvg_pkg::PT_W-1:0] cx_ext, cy_ext;

    always_comb
    begin
        cos_v  = cf_reg[S-1] ? -cx_reg[S-1] : cx_reg[S-1];
        sin_v  = cf_reg[S-1] ? -cy_reg[S-1] : cy_reg[S-1];
        rad_s  = {1'b0, radius};
        sx     = (mx_reg + RND) >>> cvg_pkg::FRAC_SH;
        sy     = (my_reg + RND) >>> cvg_pkg::FRAC_SH;
        cx_ext = {{(cvg_pkg::PT_W - cvg_pkg::CRD_W){center_x[cvg_pkg::CRD_W-1]}}, center_x};
        cy_ext = {{(cvg_pkg::PT_W - cvg_pkg::CRD_W){center_y[cvg_pkg::CRD_W-1]}}, center_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            mv_reg <= cv_reg[S-1];
            ov_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= PW'(rad_s * cos_v);
            my_reg <= PW'(rad_s * sin_v);
            px_reg <= sx[cvg_pkg::PT_W-1:0] + cx_ext;
            py_reg <= sy[cvg_pkg::PT_W-1:0] + cy_ext;
        end
    end

    assign out_valid = ov_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;

endmodule

[rtl/circle_vertex_generator.sv]
// Throughput: one vertex per cycle unless out_ready back-pressure stalls it;
// 27-stage restoring divider, 4-entry queue, 16-stage CORDIC, multiply stage and
// output register.
// Reset: rst_n asynchronous, active low; clears pipeline valids and queue,
// loads center (0,0), radius 10.0, 100 segments.
module circle_vertex_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_addr,
    input  logic [cvg_pkg::CRD_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cvg_pkg::IDX_W-1:0]     vertex_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cvg_pkg::PT_W-1:0]      point_x,
    output logic [cvg_pkg::PT_W-1:0]      point_y
);

    logic [cvg_pkg::CRD_W-1:0] center_x_reg, center_y_reg, radius_reg;
    logic [cvg_pkg::SEG_W-1:0] segments_reg;

    logic               q_full, q_empty, q_push, q_pop;
    cvg_pkg::cvg_item_t q_item, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= cvg_pkg::RST_CENTER_X;
            center_y_reg <= cvg_pkg::RST_CENTER_Y;
            radius_reg   <= cvg_pkg::RST_RADIUS;
            segments_reg <= cvg_pkg::RST_SEGMENTS;
        end
        else if (cfg_wr_en)
        begin
            case (cvg_pkg::cvg_reg_t'(cfg_addr))
                cvg_pkg::REG_CENTER_X: center_x_reg <= cfg_wdata;
                cvg_pkg::REG_CENTER_Y: center_y_reg <= cfg_wdata;
                cvg_pkg::REG_RADIUS:   radius_reg   <= cfg_wdata;
                cvg_pkg::REG_SEGMENTS: segments_reg <= cfg_wdata[cvg_pkg::SEG_W-1:0];
                default: ;
            endcase
        end
    end

    cvg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .vertex_index (vertex_index),
        .segments     (segments_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_item)
    );

    cvg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    cvg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .radius    (radius_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_x   (point_x),
        .point_y   (point_y)
    );

endmodule

[rtl/cvg_checker.sv]
module cvg_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [cvg_pkg::PT_W-1:0]      point_x,
    input  logic [cvg_pkg::PT_W-1:0]      point_y
);

    logic [6:0] pend_reg, pend_next;
    logic       in_beat, out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg + 7'(in_beat) - 7'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(point_x) && $stable(point_y))
        else $error("output payload changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("output beat without pending input");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 7'd50)
        else $error("too many beats in flight");

endmodule

bind circle_vertex_generator cvg_checker u_cvg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point_x   (point_x),
    .point_y   (point_y)
);

[tb/sv/circle_vertex_generator_tb.sv]
`timescale 1ns / 100ps

module circle_vertex_generator_tb;

    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        logic [cvg_pkg::IDX_W-1:0] idx;
        logic                      has_exp;
        logic [cvg_pkg::PT_W-1:0]  ex;
        logic [cvg_pkg::PT_W-1:0]  ey;
    } dir_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [1:0]                 cfg_addr;
    logic [cvg_pkg::CRD_W-1:0]  cfg_wdata;
    logic                       in_valid;
    logic                       in_ready;
    logic [cvg_pkg::IDX_W-1:0]  vertex_index;
    logic                       out_valid;
    logic                       out_ready;
    logic [cvg_pkg::PT_W-1:0]   point_x;
    logic [cvg_pkg::PT_W-1:0]   point_y;

    logic [cvg_pkg::CRD_W-1:0]  cx_q, cy_q, rad_q;
    logic [cvg_pkg::SEG_W-1:0]  seg_q;

    logic [cvg_pkg::PT_W-1:0]   exp_x_q[$];
    logic [cvg_pkg::PT_W-1:0]   exp_y_q[$];
    int                         n_err;
    int                         n_cycle;

    circle_vertex_generator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .vertex_index (vertex_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .point_x      (point_x),
        .point_y      (point_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void circle_point(input logic [cvg_pkg::IDX_W-1:0] idx,
                                         output logic [cvg_pkg::PT_W-1:0] px,
                                         output logic [cvg_pkg::PT_W-1:0] py);
        longint phase, z, x, y, dx, dy, t, atab[16];
        logic [31:0] turn;
        bit flip;
        atab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772,
                 166886, 83443, 41722, 20861};
        phase = 0;
        flip = 1'b0;
        if (seg_q != 0)
            phase = ((longint'(idx) << cvg_pkg::ANGLE_BITS) / longint'(seg_q)) & 16'hFFFF;
        turn = 32'(phase << (32 - cvg_pkg::ANGLE_BITS));
        z = longint'($signed(turn));
        if (z > 64'sd1073741824 || z < -64'sd1073741824)
        begin
            turn = turn - 32'h8000_0000;
            z = longint'($signed(turn));
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        for (int i = 0; i < cvg_pkg::CORDIC_STAGES; i++)
        begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atab[i];
            end
            else
            begin
                x += dx; y -= dy; z += atab[i];
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        t = longint'($signed(cx_q)) + floor_sh(longint'(rad_q) * x + (64'sd1 << 29), 30);
        px = t[cvg_pkg::PT_W-1:0];
        t = longint'($signed(cy_q)) + floor_sh(longint'(rad_q) * y + (64'sd1 << 29), 30);
        py = t[cvg_pkg::PT_W-1:0];
    endfunction

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return;
        in_valid <= 1'b0;
        if (r < 95)
            repeat ($urandom_range(1, 3)) @(negedge clk);
        else
            repeat ($urandom_range(10, 40)) @(negedge clk);
    endtask

    task automatic send_vertex(input logic [cvg_pkg::IDX_W-1:0] idx,
                               input bit has_exp,
                               input logic [cvg_pkg::PT_W-1:0] ex,
                               input logic [cvg_pkg::PT_W-1:0] ey,
                               input bit gaps);
        logic [cvg_pkg::PT_W-1:0] px, py;
        circle_point(idx, px, py);
        if (has_exp)
        begin
            px = ex;
            py = ey;
        end
        if (gaps)
            idle_gap();
        in_valid <= 1'b1;
        vertex_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        exp_x_q.push_back(px);
        exp_y_q.push_back(py);
        @(negedge clk);
    endtask

    task automatic write_reg(input cvg_pkg::cvg_reg_t r, input logic [cvg_pkg::CRD_W-1:0] v);
        in_valid <= 1'b0;
        while (exp_x_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= r;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (r)
            cvg_pkg::REG_CENTER_X: cx_q = v;
            cvg_pkg::REG_CENTER_Y: cy_q = v;
            cvg_pkg::REG_RADIUS:   rad_q = v;
            default:               seg_q = v[cvg_pkg::SEG_W-1:0];
        endcase
    endtask

    task automatic set_circle(input logic [cvg_pkg::CRD_W-1:0] cx,
                              input logic [cvg_pkg::CRD_W-1:0] cy,
                              input logic [cvg_pkg::CRD_W-1:0] r,
                              input logic [cvg_pkg::SEG_W-1:0] s);
        write_reg(cvg_pkg::REG_CENTER_X, cx);
        write_reg(cvg_pkg::REG_CENTER_Y, cy);
        write_reg(cvg_pkg::REG_RADIUS, r);
        write_reg(cvg_pkg::REG_SEGMENTS, cvg_pkg::CRD_W'(s));
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < 8)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3) + ($urandom_range(0, 19) == 0 ? 30 : 0))
                    @(negedge clk);
            end
            out_ready <= (n_cycle % 3000 < 600) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_x_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected point x=%h y=%h", point_x, point_y);
            end
            else
            begin
                if (point_x !== exp_x_q[0] || point_y !== exp_y_q[0])
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("point mismatch: expected x=%h y=%h, actual x=%h y=%h",
                                 exp_x_q[0], exp_y_q[0], point_x, point_y);
                end
                void'(exp_x_q.pop_front());
                void'(exp_y_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycle++;
        if (n_cycle > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows[$];
        int cfg_sel;
        logic [cvg_pkg::SEG_W-1:0] s;
        logic [cvg_pkg::IDX_W-1:0] v;
        n_err = 0;
        n_cycle = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = cvg_pkg::REG_CENTER_X;
        cfg_wdata = '0;
        in_valid = 1'b0;
        vertex_index = '0;
        cx_q = cvg_pkg::RST_CENTER_X;
        cy_q = cvg_pkg::RST_CENTER_Y;
        rad_q = cvg_pkg::RST_RADIUS;
        seg_q = cvg_pkg::RST_SEGMENTS;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // reset circle: r=10.0 at origin, 100 segments
        rows.push_back('{11'd0,    1'b1, 18'(2560), 18'(0)});
        rows.push_back('{11'd25,   1'b0, '0, '0});
        rows.push_back('{11'd50,   1'b0, '0, '0});
        rows.push_back('{11'd75,   1'b0, '0, '0});
        rows.push_back('{11'd100,  1'b1, 18'(2560), 18'(0)});
        rows.push_back('{11'd1024, 1'b0, '0, '0});
        rows.push_back('{11'd2047, 1'b0, '0, '0});
        rows.push_back('{11'd1365, 1'b0, '0, '0});
        foreach (rows[i])
            send_vertex(rows[i].idx, rows[i].has_exp, rows[i].ex, rows[i].ey, 1'b0);

        rows.delete();
        set_circle(16'h7FFF, 16'h8000, 16'hFFFF, 11'd1024);
        rows.push_back('{11'd0,    1'b0, '0, '0});
        rows.push_back('{11'd256,  1'b0, '0, '0});
        rows.push_back('{11'd512,  1'b0, '0, '0});
        rows.push_back('{11'd768,  1'b0, '0, '0});
        rows.push_back('{11'd1023, 1'b0, '0, '0});
        rows.push_back('{11'd1024, 1'b0, '0, '0});
        foreach (rows[i])
            send_vertex(rows[i].idx, rows[i].has_exp, rows[i].ex, rows[i].ey, 1'b0);

        rows.delete();
        set_circle(16'h1234, 16'hFEDC, 16'h0000, 11'd1);
        rows.push_back('{11'd0, 1'b1, 18'h01234, 18'h3FEDC});
        rows.push_back('{11'd7, 1'b1, 18'h01234, 18'h3FEDC});
        foreach (rows[i])
            send_vertex(rows[i].idx, rows[i].has_exp, rows[i].ex, rows[i].ey, 1'b0);

        // zero segments: phase stays at zero
        rows.delete();
        set_circle(16'h8000, 16'h7FFF, 16'h0100, 11'd0);
        rows.push_back('{11'd0,    1'b1, 18'h38100, 18'h07FFF});
        rows.push_back('{11'd2047, 1'b1, 18'h38100, 18'h07FFF});
        foreach (rows[i])
            send_vertex(rows[i].idx, rows[i].has_exp, rows[i].ex, rows[i].ey, 1'b0);

        set_circle(16'h0000, 16'h0000, 16'h0A00, 11'd2047);
        send_vertex(11'd1000, 1'b0, '0, '0, 1'b0);
        send_vertex(11'd2047, 1'b0, '0, '0, 1'b0);

        for (int ph = 0; ph < 10; ph++)
        begin
            cfg_sel = $urandom_range(0, 9);
            if (cfg_sel < 6)
                s = cvg_pkg::SEG_W'($urandom_range(1, 64));
            else if (cfg_sel < 8)
                s = cvg_pkg::SEG_W'($urandom_range(65, 1024));
            else
                s = cvg_pkg::SEG_W'($urandom_range(0, 2047));
            set_circle(cvg_pkg::CRD_W'($urandom), cvg_pkg::CRD_W'($urandom),
                       cvg_pkg::CRD_W'($urandom), s);
            for (int k = 0; k < 125; k++)
            begin
                if ($urandom_range(0, 3) != 0 && s != 0)
                    v = cvg_pkg::IDX_W'($urandom_range(0, s));
                else
                    v = cvg_pkg::IDX_W'($urandom);
                send_vertex(v, 1'b0, '0, '0, 1'b1);
            end
        end
        in_valid <= 1'b0;

        while (exp_x_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/cvg_pkg.sv
rtl/cvg_front.sv
rtl/cvg_queue.sv
rtl/cvg_back.sv
rtl/circle_vertex_generator.sv
rtl/cvg_checker.sv
tb/sv/circle_vertex_generator_tb.sv
